[rtl/core/shape_pair_collision_test_core_assert.svh]
// Assertion macros for the shape pair collision test core.
`ifndef SHAPE_PAIR_COLLISION_TEST_CORE_ASSERT_SVH
`define SHAPE_PAIR_COLLISION_TEST_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SPCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/spct_pkg.sv]
// Shared types, widths and helpers for the shape pair collision test core.
`default_nettype none

package spct_pkg;

    localparam int COORD_BITS  = 16;
    localparam int LAYER_BITS  = 8;
    localparam int FUNC_BITS   = 2;
    localparam int SIZE_BITS   = COORD_BITS - 1;
    localparam int FILTER_BITS = 2 * LAYER_BITS;
    localparam int OVL_BITS    = COORD_BITS + 1;
    // corner plus size, and differences of those, fit here
    localparam int EXT_BITS    = COORD_BITS + 2;
    // absolute per-axis gap
    localparam int GAP_BITS    = COORD_BITS + 1;
    // radius, or sum of two radii
    localparam int RAD_BITS    = COORD_BITS;
    localparam int SQ_BITS     = 2 * RAD_BITS;
    localparam int SUM_BITS    = SQ_BITS + 1;
    // radius minus gap before saturation
    localparam int DIF_BITS    = COORD_BITS + 3;

    localparam logic signed [DIF_BITS-1:0] OVL_FLOOR =
        DIF_BITS'(-((longint'(1) << COORD_BITS) - longint'(1)));

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_RR,
        FUNC_CC,
        FUNC_RC,
        FUNC_CR
    } t_func;

    // packed from the top bit down: last field of tdata first
    typedef struct packed {
        logic        [FILTER_BITS-1:0] b_filter;
        logic        [FILTER_BITS-1:0] a_filter;
        logic        [SIZE_BITS-1:0]   b_h;
        logic        [SIZE_BITS-1:0]   b_w;
        logic signed [COORD_BITS-1:0]  b_y;
        logic signed [COORD_BITS-1:0]  b_x;
        logic        [SIZE_BITS-1:0]   a_h;
        logic        [SIZE_BITS-1:0]   a_w;
        logic signed [COORD_BITS-1:0]  a_y;
        logic signed [COORD_BITS-1:0]  a_x;
    } t_pair;

    typedef struct packed {
        t_func func;
        t_pair pair;
    } t_item;

    typedef struct packed {
        logic signed [OVL_BITS-1:0] ovl_y;
        logic signed [OVL_BITS-1:0] ovl_x;
        logic                       layers_ok;
        logic                       hit;
    } t_out_data;

    typedef struct packed {
        logic      ovl_valid;
        t_out_data data;
    } t_result;

    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

    typedef struct packed {
        logic    vld;
        t_result res;
    } t_pipe_out;

    localparam int PAIR_BITS      = $bits(t_pair);
    localparam int IN_DATA_BITS   = ((PAIR_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = $bits(t_out_data);
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS  = 1;

    function automatic logic signed [EXT_BITS-1:0] ext_c(input logic signed [COORD_BITS-1:0] v);
        return EXT_BITS'(v);
    endfunction

    function automatic logic signed [EXT_BITS-1:0] ext_s(input logic [SIZE_BITS-1:0] v);
        return $signed(EXT_BITS'(v));
    endfunction

endpackage

`default_nettype wire

[rtl/core/spct_pipe.sv]
// Four-stage collision datapath: operand setup, clamp gap, squares, compare.
`default_nettype none
`include "shape_pair_collision_test_core_assert.svh"

module spct_pipe import spct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_item     i_item,
    output t_pipe_out o_out
);

    // stage 1: rect-rect test, circle centre and clamp window
    logic                       r_s1_vld;
    t_func                      r_s1_func, n_s1_func;
    logic                       r_s1_layers_ok, n_s1_layers_ok;
    logic                       r_s1_hit_rr, n_s1_hit_rr;
    logic signed [OVL_BITS-1:0] r_s1_ox_rr, n_s1_ox_rr;
    logic signed [OVL_BITS-1:0] r_s1_oy_rr, n_s1_oy_rr;
    logic signed [EXT_BITS-1:0] r_s1_cx, n_s1_cx;
    logic signed [EXT_BITS-1:0] r_s1_cy, n_s1_cy;
    logic signed [EXT_BITS-1:0] r_s1_lo_x, n_s1_lo_x;
    logic signed [EXT_BITS-1:0] r_s1_hi_x, n_s1_hi_x;
    logic signed [EXT_BITS-1:0] r_s1_lo_y, n_s1_lo_y;
    logic signed [EXT_BITS-1:0] r_s1_hi_y, n_s1_hi_y;
    logic        [RAD_BITS-1:0] r_s1_rad, n_s1_rad;

    // stage 2: absolute gaps
    logic                       r_s2_vld;
    t_func                      r_s2_func;
    logic                       r_s2_layers_ok;
    logic                       r_s2_hit_rr;
    logic signed [OVL_BITS-1:0] r_s2_ox_rr;
    logic signed [OVL_BITS-1:0] r_s2_oy_rr;
    logic        [GAP_BITS-1:0] r_s2_adx, n_s2_adx;
    logic        [GAP_BITS-1:0] r_s2_ady, n_s2_ady;
    logic        [RAD_BITS-1:0] r_s2_rad;

    // stage 3: squares and saturated overlap
    logic                       r_s3_vld;
    t_func                      r_s3_func;
    logic                       r_s3_layers_ok;
    logic                       r_s3_hit_rr;
    logic signed [OVL_BITS-1:0] r_s3_ox_rr;
    logic signed [OVL_BITS-1:0] r_s3_oy_rr;
    logic                       r_s3_near, n_s3_near;
    logic        [SQ_BITS-1:0]  r_s3_x2, n_s3_x2;
    logic        [SQ_BITS-1:0]  r_s3_y2, n_s3_y2;
    logic        [SQ_BITS-1:0]  r_s3_s2, n_s3_s2;
    logic signed [OVL_BITS-1:0] r_s3_ox_rc, n_s3_ox_rc;
    logic signed [OVL_BITS-1:0] r_s3_oy_rc, n_s3_oy_rc;

    // stage 4: result register
    logic    r_s4_vld;
    t_result r_s4_res, n_s4_res;

    function automatic logic [GAP_BITS-1:0] clamp_gap(
        input logic signed [EXT_BITS-1:0] c,
        input logic signed [EXT_BITS-1:0] lo,
        input logic signed [EXT_BITS-1:0] hi
    );
        logic signed [EXT_BITS-1:0] d;
        d = '0;
        if (c < lo) begin
            d = lo - c;
        end else if (c > hi) begin
            d = c - hi;
        end
        return d[GAP_BITS-1:0];
    endfunction

    function automatic logic signed [OVL_BITS-1:0] sat_ovl(
        input logic [RAD_BITS-1:0] r,
        input logic [GAP_BITS-1:0] g
    );
        logic signed [DIF_BITS-1:0] d;
        d = $signed(DIF_BITS'(r)) - $signed(DIF_BITS'(g));
        if (d < OVL_FLOOR) begin
            d = OVL_FLOOR;
        end
        return d[OVL_BITS-1:0];
    endfunction

    always_comb begin
        logic signed [EXT_BITS-1:0] ax, ay, aw, ah, bx, by, bw, bh;
        ax = ext_c(i_item.pair.a_x);
        ay = ext_c(i_item.pair.a_y);
        aw = ext_s(i_item.pair.a_w);
        ah = ext_s(i_item.pair.a_h);
        bx = ext_c(i_item.pair.b_x);
        by = ext_c(i_item.pair.b_y);
        bw = ext_s(i_item.pair.b_w);
        bh = ext_s(i_item.pair.b_h);

        n_s1_func   = i_item.func;
        n_s1_hit_rr = (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
        n_s1_ox_rr  = OVL_BITS'(ax - bx);
        n_s1_oy_rr  = OVL_BITS'(ay - by);
        n_s1_layers_ok =
            (|(i_item.pair.a_filter[FILTER_BITS-1:LAYER_BITS] &
               i_item.pair.b_filter[LAYER_BITS-1:0])) &&
            (|(i_item.pair.b_filter[FILTER_BITS-1:LAYER_BITS] &
               i_item.pair.a_filter[LAYER_BITS-1:0]));

        // circle-circle clamps A's centre to a point window at B's centre
        case (i_item.func)
            FUNC_RC: begin
                n_s1_cx   = bx + bw;
                n_s1_cy   = by + bw;
                n_s1_lo_x = ax;
                n_s1_hi_x = ax + aw;
                n_s1_lo_y = ay;
                n_s1_hi_y = ay + ah;
                n_s1_rad  = RAD_BITS'(i_item.pair.b_w);
            end
            FUNC_CR: begin
                n_s1_cx   = ax + aw;
                n_s1_cy   = ay + aw;
                n_s1_lo_x = bx;
                n_s1_hi_x = bx + bw;
                n_s1_lo_y = by;
                n_s1_hi_y = by + bh;
                n_s1_rad  = RAD_BITS'(i_item.pair.a_w);
            end
            default: begin
                n_s1_cx   = ax + aw;
                n_s1_cy   = ay + aw;
                n_s1_lo_x = bx + bw;
                n_s1_hi_x = bx + bw;
                n_s1_lo_y = by + bw;
                n_s1_hi_y = by + bw;
                n_s1_rad  = RAD_BITS'(i_item.pair.a_w) + RAD_BITS'(i_item.pair.b_w);
            end
        endcase
    end

    always_comb begin
        n_s2_adx = clamp_gap(r_s1_cx, r_s1_lo_x, r_s1_hi_x);
        n_s2_ady = clamp_gap(r_s1_cy, r_s1_lo_y, r_s1_hi_y);
    end

    always_comb begin
        logic [GAP_BITS-1:0] rad_g;
        logic [RAD_BITS-1:0] gx, gy;
        rad_g = GAP_BITS'(r_s2_rad);
        gx    = r_s2_adx[RAD_BITS-1:0];
        gy    = r_s2_ady[RAD_BITS-1:0];
        // once both gaps are below the radius they fit the narrow squares
        n_s3_near  = (r_s2_adx < rad_g) && (r_s2_ady < rad_g);
        n_s3_x2    = SQ_BITS'(gx) * SQ_BITS'(gx);
        n_s3_y2    = SQ_BITS'(gy) * SQ_BITS'(gy);
        n_s3_s2    = SQ_BITS'(r_s2_rad) * SQ_BITS'(r_s2_rad);
        n_s3_ox_rc = sat_ovl(r_s2_rad, r_s2_adx);
        n_s3_oy_rc = sat_ovl(r_s2_rad, r_s2_ady);
    end

    always_comb begin
        logic hit_c;
        hit_c = r_s3_near &&
                ((SUM_BITS'(r_s3_x2) + SUM_BITS'(r_s3_y2)) < SUM_BITS'(r_s3_s2));
        n_s4_res.data.layers_ok = r_s3_layers_ok;
        case (r_s3_func)
            FUNC_RR: begin
                n_s4_res.data.hit   = r_s3_hit_rr;
                n_s4_res.ovl_valid  = 1'b1;
                n_s4_res.data.ovl_x = r_s3_ox_rr;
                n_s4_res.data.ovl_y = r_s3_oy_rr;
            end
            FUNC_CC: begin
                n_s4_res.data.hit   = hit_c;
                n_s4_res.ovl_valid  = 1'b0;
                n_s4_res.data.ovl_x = '0;
                n_s4_res.data.ovl_y = '0;
            end
            default: begin
                n_s4_res.data.hit   = hit_c;
                n_s4_res.ovl_valid  = 1'b1;
                n_s4_res.data.ovl_x = r_s3_ox_rc;
                n_s4_res.data.ovl_y = r_s3_oy_rc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_s1_vld <= i_ctl.vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_s1_func      <= n_s1_func;
            r_s1_layers_ok <= n_s1_layers_ok;
            r_s1_hit_rr    <= n_s1_hit_rr;
            r_s1_ox_rr     <= n_s1_ox_rr;
            r_s1_oy_rr     <= n_s1_oy_rr;
            r_s1_cx        <= n_s1_cx;
            r_s1_cy        <= n_s1_cy;
            r_s1_lo_x      <= n_s1_lo_x;
            r_s1_hi_x      <= n_s1_hi_x;
            r_s1_lo_y      <= n_s1_lo_y;
            r_s1_hi_y      <= n_s1_hi_y;
            r_s1_rad       <= n_s1_rad;

            r_s2_func      <= r_s1_func;
            r_s2_layers_ok <= r_s1_layers_ok;
            r_s2_hit_rr    <= r_s1_hit_rr;
            r_s2_ox_rr     <= r_s1_ox_rr;
            r_s2_oy_rr     <= r_s1_oy_rr;
            r_s2_adx       <= n_s2_adx;
            r_s2_ady       <= n_s2_ady;
            r_s2_rad       <= r_s1_rad;

            r_s3_func      <= r_s2_func;
            r_s3_layers_ok <= r_s2_layers_ok;
            r_s3_hit_rr    <= r_s2_hit_rr;
            r_s3_ox_rr     <= r_s2_ox_rr;
            r_s3_oy_rr     <= r_s2_oy_rr;
            r_s3_near      <= n_s3_near;
            r_s3_x2        <= n_s3_x2;
            r_s3_y2        <= n_s3_y2;
            r_s3_s2        <= n_s3_s2;
            r_s3_ox_rc     <= n_s3_ox_rc;
            r_s3_oy_rc     <= n_s3_oy_rc;

            r_s4_res       <= n_s4_res;
        end
    end

    assign o_out.vld = r_s4_vld;
    assign o_out.res = r_s4_res;

    `SPCT_ASSERT_IMP(a_cc_no_overlap, i_clk, i_rst_n,
        r_s4_vld && !r_s4_res.ovl_valid,
        r_s4_res.data.ovl_x == '0 && r_s4_res.data.ovl_y == '0,
        "overlap fields not cleared when overlap is invalid")
    `SPCT_ASSERT_NXT(a_near_positive_ovl, i_clk, i_rst_n,
        i_ctl.en && r_s3_vld && r_s3_near && (r_s3_func == FUNC_RC || r_s3_func == FUNC_CR),
        r_s4_res.data.ovl_x > 0 && r_s4_res.data.ovl_y > 0,
        "circle within radius but overlap not positive")
    `SPCT_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n,
        !i_ctl.en && r_s2_vld && r_s3_vld,
        $stable(r_s2_adx) && $stable(r_s2_ady) && $stable(r_s3_x2) && $stable(r_s3_s2),
        "pipeline stage moved during a stall")

endmodule

`default_nettype wire

[rtl/core/shape_pair_collision_test_core.sv]
// Shape pair collision test core: stream ports, input skid register and datapath.
`default_nettype none
`include "shape_pair_collision_test_core_assert.svh"

// Tests one pair of shapes (rect-rect, circle-circle, or rect and circle,
// selected by tuser) per transfer and returns one result transfer per input.
// The datapath is a four-stage pipeline; a new pair can be taken every cycle
// while the output is not stalled. A one-entry skid register on the input
// keeps s_axis_tready registered; back-pressure on the output freezes the
// whole pipeline while the skid register absorbs one more transfer. There is
// no configuration and no state between pairs.
module shape_pair_collision_test_core import spct_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h, a_filter, b_filter, zero pad
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // func
    input  logic [FUNC_BITS-1:0]     i_s_axis_tuser,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // hit, layers_ok, overlap_x, overlap_y, zero pad
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,
    // overlap_valid
    output logic [OUT_USER_BITS-1:0] o_m_axis_tuser
);

    logic      r_skid_vld;
    t_item     r_skid_item;
    t_item     w_in_item;
    t_item     w_src_item;
    t_pipe_ctl w_ctl;
    t_pipe_out w_out;
    logic      w_in_accept;

    assign w_in_item.func = t_func'(i_s_axis_tuser);
    assign w_in_item.pair = t_pair'(i_s_axis_tdata[PAIR_BITS-1:0]);

    assign o_s_axis_tready = !r_skid_vld;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    assign w_ctl.en   = !w_out.vld || i_m_axis_tready;
    assign w_ctl.vld  = r_skid_vld || i_s_axis_tvalid;
    assign w_src_item = r_skid_vld ? r_skid_item : w_in_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (w_ctl.en) begin
            r_skid_vld <= 1'b0;
        end else if (w_in_accept) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_ctl.en && w_in_accept) begin
            r_skid_item <= w_in_item;
        end
    end

    spct_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_item  (w_src_item),
        .o_out   (w_out)
    );

    assign o_m_axis_tvalid = w_out.vld;
    assign o_m_axis_tdata  = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}}, w_out.res.data};
    assign o_m_axis_tuser  = OUT_USER_BITS'(w_out.res.ovl_valid);

    `SPCT_ASSERT_NXT(a_skid_drains, i_clk, i_rst_n,
        r_skid_vld && w_ctl.en,
        !r_skid_vld,
        "skid entry not drained when pipeline advanced")
    `SPCT_ASSERT_NXT(a_skid_catches, i_clk, i_rst_n,
        w_in_accept && !w_ctl.en,
        r_skid_vld,
        "transfer accepted during stall was not kept")
    `SPCT_ASSERT_NXT(a_skid_holds, i_clk, i_rst_n,
        r_skid_vld && !w_ctl.en,
        r_skid_vld && $stable(r_skid_item),
        "skid entry changed during stall")

endmodule

`default_nettype wire

[verif/shape_pair_collision_test_core_tb.sv]
// Self-checking testbench for the shape pair collision test core.
`timescale 1ns / 100ps

module shape_pair_collision_test_core_tb;
    import spct_pkg::*;

    typedef struct packed {
        logic                       hit;
        logic                       layers_ok;
        logic                       ovl_valid;
        logic signed [OVL_BITS-1:0] ovl_x;
        logic signed [OVL_BITS-1:0] ovl_y;
    } t_collision;

    typedef struct {
        t_func      func;
        t_pair      pair;
        bit         known;
        t_collision want;
    } t_probe;

    localparam longint OVL_LIMIT = (longint'(1) << COORD_BITS) - 1;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
    logic [FUNC_BITS-1:0]     s_axis_tuser  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic [OUT_USER_BITS-1:0] m_axis_tuser;

    t_collision pending_results[$];
    t_probe     probes[$];
    int         bad_results = 0;
    int         burst_left  = 0;
    bit         tx_idle     = 1'b1;
    logic [11:0] rx_tick    = '0;

    shape_pair_collision_test_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #4ms;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    // dx^2 + dy^2 < s^2, with s >= 0
    function automatic bit closer_than(longint dx, longint dy, longint s);
        longint mx, my;
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        if (mx >= s || my >= s)
            return 1'b0;
        return mx * mx < s * s - my * my;
    endfunction

    function automatic logic signed [OVL_BITS-1:0] clip_overlap(longint v);
        if (v > OVL_LIMIT) v = OVL_LIMIT;
        if (v < -OVL_LIMIT) v = -OVL_LIMIT;
        return OVL_BITS'(v);
    endfunction

    function automatic t_collision collide(t_func f, t_pair p);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        longint rx, ry, rw, rh, cx, cy, r, dx, dy;
        t_collision c;
        ax = $signed(p.a_x);
        ay = $signed(p.a_y);
        bx = $signed(p.b_x);
        by = $signed(p.b_y);
        aw = p.a_w;
        ah = p.a_h;
        bw = p.b_w;
        bh = p.b_h;
        c.hit       = 1'b0;
        c.ovl_valid = 1'b1;
        c.ovl_x     = '0;
        c.ovl_y     = '0;
        c.layers_ok = (|(p.a_filter[FILTER_BITS-1:LAYER_BITS] & p.b_filter[LAYER_BITS-1:0]))
                   && (|(p.b_filter[FILTER_BITS-1:LAYER_BITS] & p.a_filter[LAYER_BITS-1:0]));
        case (f)
            FUNC_RR: begin
                c.ovl_x = clip_overlap(ax - bx);
                c.ovl_y = clip_overlap(ay - by);
                c.hit   = ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by;
            end
            FUNC_CC: begin
                c.ovl_valid = 1'b0;
                c.hit = closer_than((ax + aw) - (bx + bw), (ay + aw) - (by + bw), aw + bw);
            end
            default: begin
                if (f == FUNC_RC) begin
                    rx = ax; ry = ay; rw = aw; rh = ah;
                    cx = bx; cy = by; r = bw;
                end else begin
                    rx = bx; ry = by; rw = bw; rh = bh;
                    cx = ax; cy = ay; r = aw;
                end
                cx = cx + r;
                cy = cy + r;
                dx = cx - clamp_to(cx, rx, rx + rw);
                dy = cy - clamp_to(cy, ry, ry + rh);
                c.ovl_x = clip_overlap(r - ((dx < 0) ? -dx : dx));
                c.ovl_y = clip_overlap(r - ((dy < 0) ? -dy : dy));
                c.hit   = closer_than(dx, dy, r);
            end
        endcase
        return c;
    endfunction

    // ---------------------------------------------------------------- stimulus

    task automatic add_probe(t_func f, int ax, int ay, int aw, int ah,
                             int bx, int by, int bw, int bh, int af, int bf,
                             bit known, bit hit, bit lok, bit vld, int ox, int oy);
        t_probe pr;
        pr.func            = f;
        pr.pair.a_x        = 16'(ax);
        pr.pair.a_y        = 16'(ay);
        pr.pair.a_w        = 15'(aw);
        pr.pair.a_h        = 15'(ah);
        pr.pair.b_x        = 16'(bx);
        pr.pair.b_y        = 16'(by);
        pr.pair.b_w        = 15'(bw);
        pr.pair.b_h        = 15'(bh);
        pr.pair.a_filter   = 16'(af);
        pr.pair.b_filter   = 16'(bf);
        pr.known           = known;
        pr.want.hit        = hit;
        pr.want.layers_ok  = lok;
        pr.want.ovl_valid  = vld;
        pr.want.ovl_x      = OVL_BITS'(ox);
        pr.want.ovl_y      = OVL_BITS'(oy);
        probes.push_back(pr);
    endtask

    task automatic fill_probes();
        // rects: zero size never hits; extremes of position and size
        add_probe(FUNC_RR, 0, 0, 0, 0, 0, 0, 16, 16, 'h0101, 'h0101, 1, 0, 1, 1, 0, 0);
        add_probe(FUNC_RR, -32768, 32767, 32767, 32767, 32767, -32768, 32767, 32767,
                  'h0000, 'h0000, 1, 0, 0, 1, -65535, 65535);
        add_probe(FUNC_RR, 0, 0, 16, 16, 16, 0, 16, 16, 'h0101, 'h0101, 0, 0, 0, 0, 0, 0);
        add_probe(FUNC_RR, 0, 0, 16, 16, 15, 15, 16, 16, 'h8080, 'h8080, 0, 0, 0, 0, 0, 0);
        add_probe(FUNC_RR, 100, -100, 32767, 32767, 100, -100, 32767, 32767,
                  'hFFFF, 'hFFFF, 0, 0, 0, 0, 0, 0);
        // circles: zero radius, concentric, touching, largest apart
        add_probe(FUNC_CC, 0, 0, 0, 0, 0, 0, 0, 0, 'hFFFF, 'hFFFF, 1, 0, 1, 0, 0, 0);
        add_probe(FUNC_CC, 0, 0, 16, 0, 0, 0, 16, 0, 'h0000, 'h0000, 1, 1, 0, 0, 0, 0);
        add_probe(FUNC_CC, 0, 0, 16, 0, 32, 0, 16, 0, 'h0102, 'h0201, 0, 0, 0, 0, 0, 0);
        add_probe(FUNC_CC, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767,
                  'h5533, 'hAACC, 0, 0, 0, 0, 0, 0);
        add_probe(FUNC_CC, 32767, 32767, 32767, 0, 32767, 32767, 1, 0,
                  'hFFFF, 'h0001, 0, 0, 0, 0, 0, 0);
        // rect and circle: centre inside, zero radius, gap at the overlap floor
        add_probe(FUNC_RC, 0, 0, 160, 160, 64, 64, 16, 0, 'h0201, 'h0102, 1, 1, 1, 1, 16, 16);
        add_probe(FUNC_RC, 0, 0, 160, 160, 80, 80, 0, 0, 'h0201, 'h0402, 1, 0, 0, 1, 0, 0);
        add_probe(FUNC_RC, 32767, 32767, 0, 0, -32768, -32768, 0, 0,
                  'hFF00, 'h00FF, 1, 0, 0, 1, -65535, -65535);
        add_probe(FUNC_RC, 0, 0, 16, 16, 16, 16, 16, 0, 'h0101, 'h0101, 0, 0, 0, 0, 0, 0);
        add_probe(FUNC_RC, 0, 0, 16, 16, 0, 0, 32, 0, 'h0101, 'h0101, 0, 0, 0, 0, 0, 0);
        add_probe(FUNC_RC, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767,
                  'h00FF, 'hFF00, 0, 0, 0, 0, 0, 0);
        // circle A, rect B
        add_probe(FUNC_CR, 64, 64, 16, 0, 0, 0, 160, 160, 'h0101, 'h0101, 1, 1, 1, 1, 16, 16);
        add_probe(FUNC_CR, 0, 0, 32, 32767, 32, 32, 0, 0, 'h1010, 'h1010, 0, 0, 0, 0, 0, 0);
        add_probe(FUNC_CR, 32767, -32768, 32767, 0, -32768, 32767, 32767, 32767,
                  'hFFFF, 'hFFFF, 0, 0, 0, 0, 0, 0);
        add_probe(FUNC_CR, -40, -40, 48, 0, 0, 0, 8, 8, 'h0300, 'h0003, 0, 0, 0, 0, 0, 0);
    endtask

    function automatic int pick_edge();
        case ($urandom_range(0, 3))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return 32767;
            default: return 16;
        endcase
    endfunction

    function automatic logic [FILTER_BITS-1:0] pick_filter();
        if ($urandom_range(0, 1) == 0)
            return FILTER_BITS'($urandom);
        // one layer per shape makes acceptance hinge on single mask bits
        return {LAYER_BITS'($urandom), LAYER_BITS'(1 << $urandom_range(0, LAYER_BITS - 1))};
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    base_x, base_y, span, mode;
        it.func = t_func'($urandom_range(0, 3));
        mode    = $urandom_range(0, 9);
        case (mode)
            6, 7: it.pair = PAIR_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
            8: begin
                it.pair.a_x = 16'(pick_edge());
                it.pair.a_y = 16'(pick_edge());
                it.pair.b_x = 16'(pick_edge());
                it.pair.b_y = 16'(pick_edge());
                it.pair.a_w = 15'(pick_size());
                it.pair.a_h = 15'(pick_size());
                it.pair.b_w = 15'(pick_size());
                it.pair.b_h = 15'(pick_size());
            end
            default: begin
                // shapes placed close together so that hits and misses both occur
                span   = (mode == 9) ? 32767 : 1024;
                base_x = int'($urandom_range(0, 40000)) - 20000;
                base_y = int'($urandom_range(0, 40000)) - 20000;
                it.pair.a_x = 16'(base_x);
                it.pair.a_y = 16'(base_y);
                it.pair.b_x = 16'(base_x + int'($urandom_range(0, 4000)) - 2000);
                it.pair.b_y = 16'(base_y + int'($urandom_range(0, 4000)) - 2000);
                it.pair.a_w = 15'($urandom_range(0, span));
                it.pair.a_h = 15'($urandom_range(0, span));
                it.pair.b_w = 15'($urandom_range(0, span));
                it.pair.b_h = 15'($urandom_range(0, span));
            end
        endcase
        if (mode != 6 && mode != 7) begin
            it.pair.a_filter = pick_filter();
            it.pair.b_filter = pick_filter();
        end
        return it;
    endfunction

    task automatic stop_tx();
        if (!tx_idle) begin
            s_axis_tvalid <= 1'b0;
            tx_idle = 1'b1;
        end
    endtask

    task automatic send_pair(t_func f, t_pair p, t_collision want);
        if (burst_left == 0) begin
            stop_tx();
            repeat ($urandom_range(0, 4) == 0 ? $urandom_range(9, 24) : $urandom_range(1, 8))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_BITS'(p);
        s_axis_tuser  <= f;
        tx_idle = 1'b0;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(want);
        burst_left--;
    endtask

    // hold the sender off until every result has come back
    task automatic drain();
        stop_tx();
        burst_left = 0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    initial begin : stimulus
        t_item it;
        fill_probes();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (probes[i])
            send_pair(probes[i].func, probes[i].pair,
                      probes[i].known ? probes[i].want : collide(probes[i].func, probes[i].pair));
        drain();
        for (int n = 0; n < 1000; n++) begin
            it = random_item();
            send_pair(it.func, it.pair, collide(it.func, it.pair));
            if (n == 500)
                drain();
        end
        drain();
        repeat (20) @(posedge i_clk);
        if (bad_results == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------- receiver

    // stall pattern steps with rx_tick[10:9]: free, random, 3 of 4, 1 of 16
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_tick       <= '0;
            m_axis_tready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1'b1;
            case (rx_tick[10:9])
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_axis_tready <= (rx_tick[1:0] != 2'd0);
                default: m_axis_tready <= (rx_tick[3:0] == 4'd0);
            endcase
        end
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            bad_results++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_data  got;
        t_collision want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_out_data'(m_axis_tdata[OUT_FIELD_BITS-1:0]);
            if (pending_results.size() == 0) begin
                $error("result transfer with no pair outstanding");
                bad_results++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", want.hit, got.hit);
                check_field("layers_ok", want.layers_ok, got.layers_ok);
                check_field("overlap_valid", want.ovl_valid, m_axis_tuser[0]);
                check_field("overlap_x", $signed(want.ovl_x), $signed(got.ovl_x));
                check_field("overlap_y", $signed(want.ovl_y), $signed(got.ovl_y));
            end
        end
    end

endmodule

[shape_pair_collision_test_core.f]
+incdir+rtl/core
rtl/core/spct_pkg.sv
rtl/core/spct_pipe.sv
rtl/core/shape_pair_collision_test_core.sv
verif/shape_pair_collision_test_core_tb.sv
